// ===== sv/dpkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpkv_pkg
// Shared types and codes for the depth-preferred key/value table.
// ----------------------------------------------------------------------------
package dpkv_pkg;

  localparam int KEY_W   = 62;  // stored key: raw key >> 2
  localparam int DEPTH_W = 8;
  localparam int VALUE_W = 16;
  localparam int ENTRY_W = KEY_W + DEPTH_W + VALUE_W;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_UPDATED = 3'd2;
  localparam logic [2:0] ST_KEPT    = 3'd3;
  localparam logic [2:0] ST_INSERT  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_RESP
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;        // latch request, restart scan
    logic scan;         // issue next read, compare previous
    logic decide_hit;   // first matching entry found
    logic decide_miss;  // no match: scan ended or table was empty
    logic load_out;     // move result into output register
  } dpkv_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic match;
    logic last;
    logic out_free;
  } dpkv_sts_t;

endpackage

// ===== sv/dpkv_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpkv_if
// Request and response channels of the key/value table.
// ----------------------------------------------------------------------------
interface dpkv_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [63:0]        key;
  logic [7:0]         depth;
  logic signed [15:0] value;

  modport source (output valid, req_type, key, depth, value, input ready);
  modport sink   (input valid, req_type, key, depth, value, output ready);
endinterface

interface dpkv_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

// ===== sv/depth_preferred_key_value_table.sv =====
// Sequence: IDLE takes the item; SCAN reads entries in order and compares each one
//   after its registered read; MISS follows an empty table or a scan with no match.
// Throughput: one item at a time, no new item until the result is in the output register;
//   the single read port of the entry memory sets the scan (one entry compared per cycle).
// Reset: synchronous; clears the entry count and control state, table starts empty.
//   Entry memory is not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
// depth_preferred_key_value_table
// Associative key/depth/value table, filled in order, searched linearly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module depth_preferred_key_value_table #(
  parameter int TABLE_ENTRIES = 64   // 2 .. 4096
) (
  input  logic          clk,
  input  logic          rst,
  dpkv_req_if.sink      req,
  dpkv_rsp_if.source    rsp
);

  // Controller and datapath talk only through these two bundles.
  dpkv_pkg::dpkv_cmd_t cmd;
  dpkv_pkg::dpkv_sts_t sts;

  // Sequencer: IDLE takes an item, SCAN walks entries in insertion order,
  // MISS handles the append / drop / miss case, RESP waits for the output
  // register. A new item is taken as soon as the result is parked in the
  // output register, even if the sink has not yet taken it.
  dpkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: request registers, entry memory with registered read,
  // one-entry-per-cycle compare, result and output registers.
  dpkv_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req.req_type),
    .key        (req.key),
    .depth      (req.depth),
    .value      (req.value),
    .out_vld    (rsp.valid),
    .out_rdy    (rsp.ready),
    .status     (rsp.status),
    .read_value (rsp.read_value)
  );

endmodule

// ===== sv/dpkv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpkv_ctrl
// Sequencer: accept, scan entries, decide, hand result to output register.
// ----------------------------------------------------------------------------
module dpkv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  dpkv_pkg::dpkv_sts_t sts,
  output dpkv_pkg::dpkv_cmd_t cmd
);

  dpkv_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpkv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      dpkv_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.empty ? dpkv_pkg::S_MISS : dpkv_pkg::S_SCAN;
        end
      end
      dpkv_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          cmd.decide_hit = 1'b1;
          state_next     = dpkv_pkg::S_RESP;
        end else if (sts.last) begin
          state_next = dpkv_pkg::S_MISS;
        end
      end
      dpkv_pkg::S_MISS: begin
        cmd.decide_miss = 1'b1;
        state_next      = dpkv_pkg::S_RESP;
      end
      dpkv_pkg::S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = dpkv_pkg::S_IDLE;
        end
      end
      default: state_next = dpkv_pkg::S_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == dpkv_pkg::S_SCAN || state == dpkv_pkg::S_MISS))
    else $error("accepted item did not start a scan");

  a_resp_drains: assert property (@(posedge clk) disable iff (rst)
    (state == dpkv_pkg::S_RESP && sts.out_free) |=> state == dpkv_pkg::S_IDLE)
    else $error("result not handed off when output register was free");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == dpkv_pkg::S_IDLE)
    else $error("input ready outside idle");

endmodule

// ===== sv/dpkv_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpkv_dp
// Datapath: request registers, entry memory, scan pipeline, result registers.
// ----------------------------------------------------------------------------
module dpkv_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  dpkv_pkg::dpkv_cmd_t cmd,
  output dpkv_pkg::dpkv_sts_t sts,
  input  logic                req_type,
  input  logic [63:0]         key,
  input  logic [7:0]          depth,
  input  logic signed [15:0]  value,
  output logic                out_vld,
  input  logic                out_rdy,
  output logic [2:0]          status,
  output logic signed [15:0]  read_value
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW = dpkv_pkg::KEY_W;
  localparam int DW = dpkv_pkg::DEPTH_W;
  localparam int VW = dpkv_pkg::VALUE_W;
  localparam int EW = dpkv_pkg::ENTRY_W;

  // request
  logic          type_q;
  logic [KW-1:0] key_q;
  logic [DW-1:0] depth_q;
  logic [VW-1:0] value_q;

  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic [AW-1:0] cmp_idx;
  logic          cmp_vld;

  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  logic [2:0]    res_status;
  logic [VW-1:0] res_value;

  logic          issue;
  logic          full;
  logic [KW-1:0] rd_key;
  logic [DW-1:0] rd_depth;
  logic [VW-1:0] rd_value;

  assign rd_key   = rd_data[EW-1 -: KW];
  assign rd_depth = rd_data[VW +: DW];
  assign rd_value = rd_data[VW-1:0];

  assign issue = cmd.scan && (rd_idx < count);
  assign full  = (count == CW'(TABLE_ENTRIES));

  assign sts.empty    = (count == '0);
  assign sts.match    = cmp_vld && (rd_key == key_q) &&
                        (type_q == dpkv_pkg::REQ_WRITE || rd_depth >= depth_q);
  assign sts.last     = cmp_vld && (CW'(cmp_idx) + CW'(1) == count);
  assign sts.out_free = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      type_q  <= req_type;
      key_q   <= key[63:2];
      depth_q <= depth;
      value_q <= value;
    end
  end

  // scan pipeline: address issued one cycle, compared the next
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.start) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= issue;
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= rd_idx[AW-1:0];
    end
  end

  // decision and write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmp_idx;
    if (cmd.decide_hit && type_q == dpkv_pkg::REQ_WRITE && rd_depth <= depth_q) begin
      mem_we = 1'b1;
    end else if (cmd.decide_miss && type_q == dpkv_pkg::REQ_WRITE && !full) begin
      mem_we    = 1'b1;
      mem_waddr = count[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {key_q, depth_q, value_q};
    end
    if (issue) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.decide_miss && type_q == dpkv_pkg::REQ_WRITE && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide_hit) begin
      if (type_q == dpkv_pkg::REQ_READ) begin
        res_status <= dpkv_pkg::ST_HIT;
        res_value  <= rd_value;
      end else if (rd_depth <= depth_q) begin
        res_status <= dpkv_pkg::ST_UPDATED;
        res_value  <= '0;
      end else begin
        res_status <= dpkv_pkg::ST_KEPT;
        res_value  <= '0;
      end
    end else if (cmd.decide_miss) begin
      res_value <= '0;
      if (type_q == dpkv_pkg::REQ_READ) begin
        res_status <= dpkv_pkg::ST_MISS;
      end else if (full) begin
        res_status <= dpkv_pkg::ST_FULL;
      end else begin
        res_status <= dpkv_pkg::ST_INSERT;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld <= 1'b1;
    end else if (out_rdy) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= res_status;
      read_value <= res_value;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> count == $past(count) + CW'(1))
    else $error("entry count moved by other than one");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_vld || out_rdy))
    else $error("output register overwritten before taken");

endmodule

// ===== tb/depth_preferred_key_value_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_preferred_key_value_table_tb
// Drives write and read requests into the key/value table, which starts empty.
// An in-bench copy of the table predicts each item's status and score, and a
// monitor compares every response against it in order. Both handshake sides
// idle at random. One long response stall backs the block up onto its input.
// ----------------------------------------------------------------------------
module depth_preferred_key_value_table_tb;

  localparam int TABLE_ENTRIES = 64;
  localparam int RANDOM_ITEMS  = 600;
  localparam int KEY_POOL      = 72;   // more keys than entries, so the table fills
  localparam int HOLD_AT       = 120;  // item count that starts the long response stall
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 2 * (TABLE_ENTRIES + 4);

  typedef struct packed {
    logic               req_type;
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] value;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] read_value;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dpkv_req_if req_ch ();
  dpkv_rsp_if rsp_ch ();

  depth_preferred_key_value_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the table: entries fill in order and are never evicted.
  // --------------------------------------------------------------------------
  logic [dpkv_pkg::KEY_W-1:0]   shadow_key   [TABLE_ENTRIES];
  logic [dpkv_pkg::DEPTH_W-1:0] shadow_depth [TABLE_ENTRIES];
  logic signed [15:0]           shadow_score [TABLE_ENTRIES];
  int                           shadow_fill = 0;

  request_t pending_reqs[$];   // items not yet accepted, in send order
  outcome_t awaited[$];        // predicted responses, oldest first

  int items_taken  = 0;        // accepted requests (nonblocking, read by other processes)
  int results_seen = 0;
  int mismatches   = 0;
  int status_hist[8];
  int send_wait    = 0;
  int recv_wait    = 0;
  int hold_left    = 0;
  logic hold_done  = 1'b0;

  // Applies one request to the shadow table and returns the response it must give.
  // Reads take the first entry with the same stored key and enough depth; writes
  // only look at the first entry with the same key and replace it unless it is deeper.
  function automatic outcome_t probe_table(request_t r);
    outcome_t                   o;
    logic [dpkv_pkg::KEY_W-1:0] k;
    o.status     = dpkv_pkg::ST_MISS;
    o.read_value = '0;
    k            = r.key[63:2];   // low two bits never reach the table
    if (r.req_type == dpkv_pkg::REQ_READ) begin
      for (int i = 0; i < shadow_fill; i++) begin
        if (shadow_key[i] == k && shadow_depth[i] >= r.depth) begin
          o.status     = dpkv_pkg::ST_HIT;
          o.read_value = shadow_score[i];
          return o;
        end
      end
      return o;
    end
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_key[i] == k) begin
        if (shadow_depth[i] <= r.depth) begin
          shadow_depth[i] = r.depth;
          shadow_score[i] = r.value;
          o.status        = dpkv_pkg::ST_UPDATED;
        end else begin
          o.status = dpkv_pkg::ST_KEPT;
        end
        return o;
      end
    end
    if (shadow_fill < TABLE_ENTRIES) begin
      shadow_key[shadow_fill]   = k;
      shadow_depth[shadow_fill] = r.depth;
      shadow_score[shadow_fill] = r.value;
      shadow_fill++;
      o.status = dpkv_pkg::ST_INSERT;
    end else begin
      o.status = dpkv_pkg::ST_FULL;   // full table drops new keys, nothing is evicted
    end
    return o;
  endfunction

  // Per-item idle draw. Every third stretch of 40 items runs with no idling.
  function automatic int idle_cycles(int n);
    if ((n / 40) % 3 == 1) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic queue_req(logic rt, logic [63:0] k, logic [7:0] d, logic signed [15:0] v);
    request_t r;
    r.req_type = rt;
    r.key      = k;
    r.depth    = d;
    r.value    = v;
    pending_reqs.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: pops the pending queue, predicts at acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_wait = idle_cycles(0);
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited.push_back(probe_table(pending_reqs.pop_front()));
        items_taken <= items_taken + 1;
        send_wait = idle_cycles(items_taken + 1);
      end
      if (req_ch.valid && !req_ch.ready) begin
        // item still on offer, payload holds
      end else if (send_wait > 0) begin
        send_wait--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs[0];
        req_ch.req_type <= nxt.req_type;
        req_ch.key      <= nxt.key;
        req_ch.depth    <= nxt.depth;
        req_ch.value    <= nxt.value;
        req_ch.valid    <= 1'b1;   // stays high back to back when no gap was drawn
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Long response stall, once: the request side keeps offering, so the block
  // finishes its current item, holds the response, and stops taking requests.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: in-order compare against the predicted queue.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        status_hist[rsp_ch.status]++;
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected response: status %0d value %0d",
                     $realtime, rsp_ch.status, rsp_ch.read_value);
        end else begin
          want = awaited.pop_front();
          if (want.status !== rsp_ch.status || want.read_value !== rsp_ch.read_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] response %0d: status exp %0d got %0d, value exp %0d got %0d",
                       $realtime, results_seen, want.status, rsp_ch.status,
                       want.read_value, rsp_ch.read_value);
          end
        end
        recv_wait = idle_cycles(results_seen);
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: stops a hung run with a failure.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset, end of run.
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0]        key_pool [KEY_POOL];
    logic [63:0]        k;
    logic [7:0]         d;
    logic               rt;
    logic               wr;
    logic               rd;
    logic [63:0]        k_lo;
    logic [63:0]        k_hi;
    logic [63:0]        k_top;
    int                 tail;

    req_ch.valid    = 1'b0;
    req_ch.req_type = dpkv_pkg::REQ_WRITE;
    req_ch.key      = '0;
    req_ch.depth    = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    foreach (status_hist[i]) status_hist[i] = 0;

    wr    = dpkv_pkg::REQ_WRITE;
    rd    = dpkv_pkg::REQ_READ;
    k_lo  = 64'h0;
    k_hi  = 64'hFFFF_FFFF_FFFF_FFFF;
    k_top = 64'h8000_0000_0000_0000;

    // directed: empty table, extremes, low-bit aliasing, depth ties and ordering
    queue_req(rd, k_lo,        8'd0,   16'sd0);       // read of empty table
    queue_req(wr, k_lo,        8'd0,   16'sh8000);    // insert, smallest everything
    queue_req(wr, k_hi,        8'd255, 16'sd32767);   // insert, largest everything
    queue_req(rd, k_lo | 64'd3, 8'd0,  16'sd77);      // alias on low bits, hit
    queue_req(rd, k_hi,        8'd255, -16'sd1);      // exact depth, hit
    queue_req(wr, k_hi ^ 64'd3, 8'd100, 16'sd9);      // stored deeper: kept
    queue_req(wr, k_lo | 64'd1, 8'd0,  16'sd5);       // equal depth: updated
    queue_req(rd, k_lo,        8'd1,   16'sd0);       // too shallow: miss
    queue_req(wr, k_lo,        8'd200, -16'sd1);      // deeper write: updated
    queue_req(rd, k_lo | 64'd2, 8'd200, 16'sd0);      // hit -1
    queue_req(rd, k_hi,        8'd0,   16'sd0);       // hit 32767
    queue_req(rd, 64'h4,       8'd0,   16'sd0);       // neighbor key: miss
    queue_req(wr, k_top,       8'd128, 16'sd0);       // insert, top key bit
    queue_req(wr, k_top | 64'd3, 8'd127, 16'sd3);     // one shallower: kept
    queue_req(rd, k_top,       8'd128, 16'sd0);       // hit 0
    queue_req(rd, k_top,       8'd129, 16'sd0);       // one too deep: miss
    queue_req(wr, k_hi,        8'd255, 16'sd1234);    // tie at max depth: updated
    queue_req(rd, k_hi,        8'd255, 16'sd0);       // hit 1234
    queue_req(wr, 64'h5555_5555_5555_5555, 8'hAA, 16'sh5555);
    queue_req(wr, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 16'shAAAA);
    queue_req(rd, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 16'sh5555);
    queue_req(rd, 64'h5555_5555_5555_5554, 8'hAB, 16'sh0);  // miss by one depth

    // random: mostly keys from a pool so writes collide and reads hit; the pool
    // is larger than the table so it fills and later new keys are dropped
    foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
    key_pool[0] = k_lo;
    key_pool[1] = k_hi;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      rt = $urandom_range(0, 1) ? rd : wr;
      if ($urandom_range(0, 99) < 85)
        k = {key_pool[$urandom_range(0, KEY_POOL - 1)][63:2], 2'($urandom_range(0, 3))};
      else
        k = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
        0:       d = 8'd0;
        1:       d = 8'd255;
        default: d = 8'($urandom_range(0, 255));
      endcase
      queue_req(rt, k, d, 16'($urandom_range(0, 65535)));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (!(items_taken == 22 + RANDOM_ITEMS && awaited.size() == 0))
      @(posedge clk);
    for (tail = 0; tail < TAIL_CYCLES; tail++)
      @(posedge clk);

    $display("%0d items: %0d hit, %0d miss, %0d upd, %0d kept, %0d ins, %0d drop.",
             results_seen, status_hist[dpkv_pkg::ST_HIT], status_hist[dpkv_pkg::ST_MISS],
             status_hist[dpkv_pkg::ST_UPDATED], status_hist[dpkv_pkg::ST_KEPT],
             status_hist[dpkv_pkg::ST_INSERT], status_hist[dpkv_pkg::ST_FULL]);
    $display("Table ended %0d of %0d full; responses were held back %0d cycles once.",
             shadow_fill, TABLE_ENTRIES, HOLD_CYCLES);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dpkv_pkg.sv
sv/dpkv_if.sv
sv/dpkv_ctrl.sv
sv/dpkv_dp.sv
sv/depth_preferred_key_value_table.sv
tb/depth_preferred_key_value_table_tb.sv
